@@ design/tmr_pkg.sv @@
`timescale 1ns / 1ps

package tmr_pkg;

  localparam int HDR_W  = 64;
  localparam int WORD_W = 32;
  localparam int SC_W   = 5;
  localparam int WIDX_W = 4;

  localparam logic [SC_W-1:0] SLOT_COUNT_RST = 5'd16;

  localparam logic [0:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [0:0] CFG_DOORBELL   = 1'b1;

  localparam logic [1:0] MODE_STAGE = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_NOMATCH = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REPLY,
    S_SEND_HDR,
    S_SEND_RD,
    S_SEND_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_HSW_RD,
    S_HSW_WA,
    S_HSW_WB,
    S_PSW_RA,
    S_PSW_RB,
    S_PSW_WA,
    S_PSW_WB
  } state_t;

  typedef struct packed {
    logic hdr_we;
    logic hdr_re;
    logic pay_we;
    logic pay_re;
  } store_ctl_t;

endpackage

@@ design/tmr_slot_store.sv @@
`timescale 1ns / 1ps

module tmr_slot_store import tmr_pkg::*; #(
  parameter int RING_DEPTH = 16,
  parameter int PAYLOAD_WORDS = 14,
  localparam int SLOT_W = $clog2(RING_DEPTH),
  localparam int IW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1,
  localparam int PAW = $clog2(RING_DEPTH * PAYLOAD_WORDS)
) (
  input  logic              clk,
  input  store_ctl_t        ctl,
  input  logic [SLOT_W-1:0] hdr_wslot,
  input  logic [HDR_W-1:0]  hdr_wdata,
  input  logic [SLOT_W-1:0] hdr_rslot,
  output logic [HDR_W-1:0]  hdr_rdata,
  input  logic [SLOT_W-1:0] pay_wslot,
  input  logic [IW-1:0]     pay_wword,
  input  logic [WORD_W-1:0] pay_wdata,
  input  logic [SLOT_W-1:0] pay_rslot,
  input  logic [IW-1:0]     pay_rword,
  output logic [WORD_W-1:0] pay_rdata
);

  logic [HDR_W-1:0]  hdr_mem [RING_DEPTH];
  logic [WORD_W-1:0] pay_mem [RING_DEPTH * PAYLOAD_WORDS];
  logic [PAW-1:0]    pay_waddr;
  logic [PAW-1:0]    pay_raddr;

  assign pay_waddr = PAW'(int'(pay_wslot) * PAYLOAD_WORDS + int'(pay_wword));
  assign pay_raddr = PAW'(int'(pay_rslot) * PAYLOAD_WORDS + int'(pay_rword));

  always_ff @(posedge clk) begin
    if (ctl.hdr_we) begin
      hdr_mem[hdr_wslot] <= hdr_wdata;
    end
    if (ctl.hdr_re) begin
      hdr_rdata <= hdr_mem[hdr_rslot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (ctl.pay_re) begin
      pay_rdata <= pay_mem[pay_raddr];
    end
  end

endmodule

@@ design/token_matched_message_ring.sv @@
`timescale 1ns / 1ps

// Message ring: a queue of RING_DEPTH slots, each a 64-bit header plus PAYLOAD_WORDS words.
// Input channel (in_valid/in_ready) takes one item: stage a payload word, send the staged
// message to the tail, or receive the first message matching a token (or group/service/type
// with id_match). Output channel (out_valid/out_ready) returns one result per stage or
// send item, one result for an empty or unmatched receive, or PAYLOAD_WORDS word results
// for a matched receive; last marks the final result of an item.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while the block is
// idle; the block itself does not enforce it. One item at a time; in_ready is high only
// while the sequencer is idle. Steps per item:
//   stage, full send, empty receive or unused mode: decode, then the reply
//   send: a header write, then per word one staged word read and one slot word write,
//     then the reply
//   receive without a match: one header read and compare per slot searched, then the reply
//   receive with a match: the search, a header swap (head header read, match written to
//     head, old head header written to the match slot), then per word a payload swap (head
//     word read, matched word read and written to head with its word result, old head word
//     written back) on one read and one write port; in_ready returns after the last write.
// A stalled receiver holds the output register; the sequencer waits on it and resumes.
// Reset empties the queue (head = tail = 0), clears the staged words, sets slot_count
// to 16 and the doorbell pattern to 0. Slot contents are undefined until written.
module token_matched_message_ring import tmr_pkg::*; #(
  parameter int RING_DEPTH = 16,
  parameter int PAYLOAD_WORDS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [15:0]       group_id,
  input  logic [7:0]        svc_id,
  input  logic [7:0]        msg_type,
  input  logic [15:0]       data_len,
  input  logic [15:0]       token,
  input  logic              id_match,
  input  logic [3:0]        word_index,
  input  logic [31:0]       payload_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              ring_doorbell,
  output logic [31:0]       doorbell_data,
  output logic [7:0]        rcv_svc_id,
  output logic [15:0]       rcv_token,
  output logic [15:0]       rcv_len,
  output logic              word_valid,
  output logic [31:0]       out_word,
  output logic              last
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CW = ($clog2(RING_DEPTH + 1) > SC_W) ? $clog2(RING_DEPTH + 1) : SC_W;
  localparam int IW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int WX = (IW > WIDX_W) ? IW : WIDX_W;

  state_t state, state_next;

  logic [SC_W-1:0]   slot_count;
  logic [31:0]       bell_value;
  logic [SLOT_W-1:0] head, tail, pos;
  logic [CW-1:0]     steps;
  logic [IW-1:0]     wcnt;

  logic [1:0]        req_mode;
  logic [15:0]       req_group;
  logic [7:0]        req_service;
  logic [7:0]        req_type;
  logic [15:0]       req_len;
  logic [15:0]       req_token;
  logic              req_no_rx;
  logic [WIDX_W-1:0] req_widx;
  logic [WORD_W-1:0] req_pword;

  logic [HDR_W-1:0]  match_hdr;
  logic [WORD_W-1:0] pay_tmp;
  logic [1:0]        reply_status;
  logic              reply_db;

  logic [WORD_W-1:0]        stg_mem [PAYLOAD_WORDS];
  logic [PAYLOAD_WORDS-1:0] stg_vld;
  logic [WORD_W-1:0]        stg_rdata;
  logic                     stg_rvld;

  store_ctl_t        store_ctl;
  logic [SLOT_W-1:0] hdr_wslot, hdr_rslot, pay_wslot, pay_rslot;
  logic [HDR_W-1:0]  hdr_wdata, hdr_rdata;
  logic [WORD_W-1:0] pay_wdata, pay_rdata;

  logic [CW-1:0]     sc_x, active, steps_inc;
  logic [SLOT_W-1:0] head_nx, tail_nx, pos_nx;
  logic [WX-1:0]     widx_x;
  logic [IW-1:0]     widx_i;
  logic              widx_ok;
  logic              wlast;
  logic              hit;
  logic              full;
  logic              out_free;
  logic              out_load;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i,
                                                  input logic [CW-1:0] act);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= act) ? '0 : n[SLOT_W-1:0];
  endfunction

  always_comb begin
    sc_x = CW'(slot_count);
    if (sc_x < CW'(2)) begin
      active = CW'(2);
    end else if (sc_x > CW'(RING_DEPTH)) begin
      active = CW'(RING_DEPTH);
    end else begin
      active = sc_x;
    end
  end

  assign head_nx   = ring_next(head, active);
  assign tail_nx   = ring_next(tail, active);
  assign pos_nx    = ring_next(pos, active);
  assign steps_inc = steps + CW'(1);
  assign full      = (tail_nx == head);
  assign wlast     = (wcnt == IW'(PAYLOAD_WORDS - 1));
  assign widx_x    = WX'(req_widx);
  assign widx_i    = widx_x[IW-1:0];
  assign widx_ok   = (widx_x < WX'(PAYLOAD_WORDS));
  assign hit       = (hdr_rdata[63:48] == req_token) ||
                     (req_no_rx && (hdr_rdata[31:0] == {req_type, req_service, req_group}));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (req_mode)
          MODE_SEND: state_next = full ? S_REPLY : S_SEND_HDR;
          MODE_RECV: state_next = (head == tail) ? S_REPLY : S_SRCH_RD;
          default:   state_next = S_REPLY;
        endcase
      end
      S_REPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SEND_HDR: state_next = S_SEND_RD;
      S_SEND_RD:  state_next = S_SEND_WR;
      S_SEND_WR:  state_next = wlast ? S_REPLY : S_SEND_RD;
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (hit) begin
          state_next = S_HSW_RD;
        end else if ((pos_nx == tail) || (steps_inc >= active)) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_HSW_RD: state_next = S_HSW_WA;
      S_HSW_WA: state_next = S_HSW_WB;
      S_HSW_WB: state_next = S_PSW_RA;
      S_PSW_RA: state_next = S_PSW_RB;
      S_PSW_RB: state_next = S_PSW_WA;
      S_PSW_WA: begin
        if (out_free) state_next = S_PSW_WB;
      end
      S_PSW_WB: state_next = wlast ? S_IDLE : S_PSW_RA;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    store_ctl = '0;
    hdr_wslot = pos;
    hdr_wdata = hdr_rdata;
    hdr_rslot = head;
    pay_wslot = pos;
    pay_wdata = pay_tmp;
    pay_rslot = head;
    out_load  = 1'b0;
    unique case (state)
      S_SEND_HDR: begin
        store_ctl.hdr_we = 1'b1;
        hdr_wslot = tail;
        hdr_wdata = {req_token, req_len, req_type, req_service, req_group};
      end
      S_SEND_WR: begin
        store_ctl.pay_we = 1'b1;
        pay_wslot = tail;
        pay_wdata = stg_rvld ? stg_rdata : '0;
      end
      S_SRCH_RD: begin
        store_ctl.hdr_re = 1'b1;
        hdr_rslot = pos;
      end
      S_HSW_RD: store_ctl.hdr_re = 1'b1;
      S_HSW_WA: begin
        store_ctl.hdr_we = 1'b1;
        hdr_wslot = head;
        hdr_wdata = match_hdr;
      end
      S_HSW_WB: store_ctl.hdr_we = 1'b1;
      S_PSW_RA: store_ctl.pay_re = 1'b1;
      S_PSW_RB: begin
        store_ctl.pay_re = 1'b1;
        pay_rslot = pos;
      end
      S_PSW_WA: begin
        store_ctl.pay_we = out_free;
        pay_wslot = head;
        pay_wdata = pay_rdata;
        out_load  = out_free;
      end
      S_PSW_WB: store_ctl.pay_we = 1'b1;
      S_REPLY:  out_load = out_free;
      default: begin
      end
    endcase
  end

  tmr_slot_store #(
    .RING_DEPTH    (RING_DEPTH),
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_store (
    .clk       (clk),
    .ctl       (store_ctl),
    .hdr_wslot (hdr_wslot),
    .hdr_wdata (hdr_wdata),
    .hdr_rslot (hdr_rslot),
    .hdr_rdata (hdr_rdata),
    .pay_wslot (pay_wslot),
    .pay_wword (wcnt),
    .pay_wdata (pay_wdata),
    .pay_rslot (pay_rslot),
    .pay_rword (wcnt),
    .pay_rdata (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      slot_count <= SLOT_COUNT_RST;
      bell_value <= '0;
      stg_vld    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOT_COUNT: slot_count <= cfg_wdata[SC_W-1:0];
          CFG_DOORBELL:   bell_value <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state == S_DECODE && req_mode == MODE_STAGE && widx_ok) begin
        stg_vld[widx_i] <= 1'b1;
      end
      if (state == S_SEND_WR && wlast) begin
        tail <= tail_nx;
      end
      if (state == S_PSW_WB && wlast) begin
        head <= head_nx;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_mode    <= mode;
      req_group   <= group_id;
      req_service <= svc_id;
      req_type    <= msg_type;
      req_len     <= data_len;
      req_token   <= token;
      req_no_rx   <= id_match;
      req_widx    <= word_index;
      req_pword   <= payload_word;
    end
    unique case (state)
      S_DECODE: begin
        pos      <= head;
        steps    <= '0;
        wcnt     <= '0;
        reply_db <= 1'b0;
        case (req_mode)
          MODE_STAGE: begin
            reply_status <= STAT_OK;
            if (widx_ok) stg_mem[widx_i] <= req_pword;
          end
          MODE_SEND: reply_status <= full ? STAT_FULL : STAT_OK;
          MODE_RECV: reply_status <= (head == tail) ? STAT_EMPTY : STAT_OK;
          default:   reply_status <= STAT_OK;
        endcase
      end
      S_SEND_RD: begin
        stg_rdata <= stg_mem[wcnt];
        stg_rvld  <= stg_vld[wcnt];
      end
      S_SEND_WR: begin
        if (wlast) begin
          reply_db <= 1'b1;
        end else begin
          wcnt <= wcnt + IW'(1);
        end
      end
      S_SRCH_CMP: begin
        if (hit) begin
          match_hdr <= hdr_rdata;
        end else begin
          pos          <= pos_nx;
          steps        <= steps_inc;
          reply_status <= STAT_NOMATCH;
        end
      end
      S_HSW_WB: wcnt <= '0;
      S_PSW_RB: pay_tmp <= pay_rdata;
      S_PSW_WB: begin
        if (!wlast) wcnt <= wcnt + IW'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (state == S_PSW_WA) begin
        status        <= STAT_OK;
        ring_doorbell <= 1'b0;
        doorbell_data <= '0;
        rcv_svc_id    <= match_hdr[23:16];
        rcv_token     <= match_hdr[63:48];
        rcv_len       <= match_hdr[47:32];
        word_valid    <= 1'b1;
        out_word      <= pay_rdata;
        last          <= wlast;
      end else begin
        status        <= reply_status;
        ring_doorbell <= reply_db;
        doorbell_data <= reply_db ? bell_value : '0;
        rcv_svc_id    <= '0;
        rcv_token     <= '0;
        rcv_len       <= '0;
        word_valid    <= 1'b0;
        out_word      <= '0;
        last          <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_valid |-> status == STAT_OK && !ring_doorbell)
    else $error("word result with bad status");

  a_hdr_port: assert property (@(posedge clk) disable iff (rst)
    !(store_ctl.hdr_we && store_ctl.hdr_re))
    else $error("header read and write in one cycle");

  a_head_move: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && head != $past(head) |-> $past(state) == S_PSW_WB)
    else $error("head moved outside receive");

  a_tail_move: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && tail != $past(tail) |-> $past(state) == S_SEND_WR)
    else $error("tail moved outside send");
`endif

endmodule
